FILE: rtl/greedy_dual_hop_cost_cache_assert.svh
// assertion macros for the cost cache checker
`ifndef GREEDY_DUAL_HOP_COST_CACHE_ASSERT_SVH
`define GREEDY_DUAL_HOP_COST_CACHE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define GDC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// next-cycle implication
`define GDC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

FILE: rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// shared constants and types of the hop cost cache
// ----------------------------------------------------------------------------
package gdc_pkg;
	localparam int CAPACITY_DEF = 16;
	localparam int PRIO_BITS_DEF = 32;
	localparam int KEY_W = 64;
	localparam int HOP_W = 8;
	localparam int CFG_W = 5;
	localparam int OUT_PRIO_W = 32;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_PROBE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch request, compute match
		logic evict;     // drop front entry, take its priority as L
		logic remove;    // drop matched entry
		logic insert;    // insert request key at new priority
		logic done;      // drive result strobe
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic full;
		logic is_update;
		logic is_store;
	} dp_sts_t;
endpackage

FILE: rtl/gdc_ctrl.sv
// ----------------------------------------------------------------------------
// gdc_ctrl
// sequencer: capture, then remove or evict and insert where needed, report
// ----------------------------------------------------------------------------
module gdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gdc_pkg::dp_sts_t sts,
	output gdc_pkg::dp_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.hit && sts.is_update) begin
					cmd.remove = 1'b1;
					state_d = ST_INSERT;
				end else if (!sts.hit && sts.is_store) begin
					cmd.evict = sts.full;
					state_d = ST_INSERT;
				end else begin
					cmd.done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/gdc_datapath.sv
// ----------------------------------------------------------------------------
// gdc_datapath
// sorted entry row with parallel key match and shift-based remove/insert
// ----------------------------------------------------------------------------
module gdc_datapath #(
	parameter int CAPACITY = gdc_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = gdc_pkg::PRIO_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  op,
	input  logic [gdc_pkg::KEY_W-1:0]   req_key,
	input  logic [gdc_pkg::HOP_W-1:0]   hop_cost,
	input  logic                        cfg_we,
	input  logic [gdc_pkg::CFG_W-1:0]   cfg_wdata,
	input  gdc_pkg::dp_cmd_t            cmd,
	output gdc_pkg::dp_sts_t            sts,
	output logic                        done,
	output logic                        hit,
	output logic                        evicted,
	output logic [gdc_pkg::KEY_W-1:0]   evicted_key,
	output logic [gdc_pkg::OUT_PRIO_W-1:0] assigned_priority,
	output logic [gdc_pkg::OUT_PRIO_W-1:0] inflation_now
);
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [PRIORITY_BITS-1:0] PMAX = '1;

	logic [gdc_pkg::KEY_W-1:0] key_q [CAPACITY];
	logic [PRIORITY_BITS-1:0]  prio_q [CAPACITY];
	logic [CAPACITY-1:0]       match_q;
	logic [OCC_W-1:0]          occ_q;
	logic [PRIORITY_BITS-1:0]  infl_q;
	logic [gdc_pkg::CFG_W-1:0] cap_q;
	logic [1:0]                op_q;
	logic [gdc_pkg::KEY_W-1:0] rkey_q;
	logic [gdc_pkg::HOP_W-1:0] hop_q;
	logic                      hit_q;
	logic                      ev_q;
	logic [gdc_pkg::KEY_W-1:0] evk_q;
	logic [PRIORITY_BITS-1:0]  aprio_q;
	logic                      done_q;

	logic [OCC_W-1:0]          eff_cap;
	logic [PRIORITY_BITS-1:0]  base_l;
	logic [PRIORITY_BITS:0]    sum;
	logic [PRIORITY_BITS-1:0]  newp;
	logic [CAPACITY-1:0]       le_v;
	logic [CAPACITY-1:0]       drop_v;

	// effective capacity, clamped to one..CAPACITY
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (32'(cap_q) > CAPACITY) begin
			eff_cap = OCC_W'(CAPACITY);
		end else begin
			eff_cap = OCC_W'(cap_q);
		end
	end

	// L seen by the new priority: front priority when evicting this step
	assign base_l = cmd.evict ? prio_q[0] : infl_q;
	assign sum = {1'b0, base_l} + {{(PRIORITY_BITS + 1 - gdc_pkg::HOP_W){1'b0}}, hop_q};
	assign newp = sum[PRIORITY_BITS] ? PMAX : sum[PRIORITY_BITS-1:0];

	assign sts.hit = |match_q;
	assign sts.full = (occ_q >= eff_cap) && (occ_q != '0);
	assign sts.is_update = (op_q == gdc_pkg::OP_LOOKUP) || (op_q == gdc_pkg::OP_STORE);
	assign sts.is_store = (op_q == gdc_pkg::OP_STORE);

	// insertion goes behind every valid entry with priority <= new one
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le_v[i] = (OCC_W'(i) < occ_q) && (prio_q[i] <= aprio_q);
		end
	end

	// entries at or after the drop point: all on evict, else from the match on
	always_comb begin
		drop_v[0] = cmd.evict | match_q[0];
		for (int i = 1; i < CAPACITY; i++) begin
			drop_v[i] = drop_v[i - 1] | match_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			infl_q <= '0;
			cap_q <= gdc_pkg::CAP_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.evict) begin
				infl_q <= prio_q[0];
			end
			if (cmd.remove || cmd.evict) begin
				occ_q <= occ_q - OCC_W'(1);
			end else if (cmd.insert && (32'(occ_q) < CAPACITY)) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// entry row and per-request registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			rkey_q <= req_key;
			hop_q <= hop_cost;
			hit_q <= 1'b0;
			ev_q <= 1'b0;
			evk_q <= '0;
			aprio_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				match_q[i] <= (OCC_W'(i) < occ_q) && (key_q[i] == req_key);
			end
		end
		if (!cmd.capture && !cmd.insert && (cmd.remove || cmd.evict || cmd.done)) begin
			hit_q <= |match_q;
		end
		if (cmd.remove || cmd.evict) begin
			aprio_q <= newp;
			if (cmd.evict) begin
				ev_q <= 1'b1;
				evk_q <= key_q[0];
			end
			// close the gap: entries at or after the drop point move down
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (drop_v[i]) begin
					key_q[i] <= key_q[i + 1];
					prio_q[i] <= prio_q[i + 1];
				end
			end
		end else if (!cmd.capture && !cmd.insert && !cmd.done && sts.is_store) begin
			// store miss without eviction
			aprio_q <= newp;
		end
		if (cmd.insert && (32'(occ_q) < CAPACITY)) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!le_v[i] && (OCC_W'(i) <= occ_q)) begin
					if (i == 0 || le_v[(i == 0) ? 0 : i - 1]) begin
						key_q[i] <= rkey_q;
						prio_q[i] <= aprio_q;
					end else begin
						key_q[i] <= key_q[(i == 0) ? 0 : i - 1];
						prio_q[i] <= prio_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign evicted = ev_q;
	assign evicted_key = evk_q;
	assign assigned_priority = gdc_pkg::OUT_PRIO_W'(aprio_q);
	assign inflation_now = gdc_pkg::OUT_PRIO_W'(infl_q);
endmodule

FILE: rtl/greedy_dual_hop_cost_cache.sv
// ----------------------------------------------------------------------------
// greedy_dual_hop_cost_cache
// cost-aware greedy-dual cache over a sorted row of key/priority entries
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Probes, the spare op
// code and lookup misses finish in the decide state; lookup hits and stores
// also pass the insert state, for the remove-then-insert step on the sorted
// entry row. The result comes from registers. busy also covers the result
// cycle, so the next request is taken in the cycle after the result at the
// earliest; requests never overlap. The result shows on the ports for one
// cycle, flagged by done; the receiver cannot stall, so it must take every
// transfer as it appears. The user must write capacity_in_use through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module greedy_dual_hop_cost_cache #(
	parameter int CAPACITY = gdc_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = gdc_pkg::PRIO_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     op,
	input  logic [gdc_pkg::KEY_W-1:0]      req_key,
	input  logic [gdc_pkg::HOP_W-1:0]      hop_cost,
	input  logic                           cfg_we,
	input  logic [gdc_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                           done,
	output logic                           hit,
	output logic                           evicted,
	output logic [gdc_pkg::KEY_W-1:0]      evicted_key,
	output logic [gdc_pkg::OUT_PRIO_W-1:0] assigned_priority,
	output logic [gdc_pkg::OUT_PRIO_W-1:0] inflation_now
);
	gdc_pkg::dp_cmd_t cmd;
	gdc_pkg::dp_sts_t sts;
	logic             ctrl_busy;
	logic             ctrl_start;

	// no request is taken while the result strobe is out
	assign ctrl_start = start & ~done;

	// sequencer
	gdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl_start),
		.busy   (ctrl_busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// entry row, inflation level and result registers
	gdc_datapath #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.req_key           (req_key),
		.hop_cost          (hop_cost),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.cmd               (cmd),
		.sts               (sts),
		.done              (done),
		.hit               (hit),
		.evicted           (evicted),
		.evicted_key       (evicted_key),
		.assigned_priority (assigned_priority),
		.inflation_now     (inflation_now)
	);

	// stay busy through the strobe cycle so results never overlap
	assign busy = ctrl_busy | done;
endmodule

FILE: rtl/gdc_checker.sv
// ----------------------------------------------------------------------------
// gdc_checker
// port-level checks of the cost cache
// ----------------------------------------------------------------------------
`include "greedy_dual_hop_cost_cache_assert.svh"
module gdc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      hit,
	input logic                      evicted,
	input logic [gdc_pkg::KEY_W-1:0] evicted_key
);
	`GDC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`GDC_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`GDC_ASSERT_IMP(a_evict_miss, clk, arst_n, done && evicted, !hit)
	`GDC_ASSERT_IMP(a_evk_zero, clk, arst_n, done && !evicted, evicted_key == '0)
	`GDC_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done)
endmodule

bind greedy_dual_hop_cost_cache gdc_checker u_gdc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.done              (done),
	.hit               (hit),
	.evicted           (evicted),
	.evicted_key       (evicted_key)
);
